// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the free-memory trend monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Condition a must imply condition c in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");

// Condition a must imply condition c in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)

`endif

`endif

// ===== rtl/fmtm_pkg.sv =====
// Package of the free-memory trend monitor: defaults, register indexes and level codes.
package fmtm_pkg;

  localparam int unsigned WINDOW_PAST_DEF = 5;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  localparam int unsigned CNT_W   = 8;
  localparam int unsigned THR_W   = 24;
  localparam int unsigned CFG_A_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX        = '1;
  localparam logic [THR_W-1:0] WARN_RESET     = 24'd80000;
  localparam logic [THR_W-1:0] DANGER_RESET   = 24'd120000;
  localparam logic [CNT_W-1:0] REF_PT_RESET   = 8'd7;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_WARNING   = 2'd0,
    CFG_DANGER    = 2'd1,
    CFG_REF_POINT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LVL_NORMAL  = 2'd0,
    LVL_WARNING = 2'd1,
    LVL_DANGER  = 2'd2
  } level_e;

endpackage

// ===== rtl/free_memory_trend_monitor_top.sv =====
// Top level of the free-memory trend monitor: sample window, extremes, average, drift, grading.
//
//  channel  | direction | contents (lowest bit first)
//  ---------+-----------+--------------------------------------------------------------------
//  s_axis   | in        | free_bytes
//  m_axis   | out       | level, average_q4, average_valid, step_change, drift_q4,
//           |           | lowest_seen, highest_seen
//  cfg      | in        | register index and write data (always ready)
//
// One sample is taken every cycle unless the output stalls. Stage one updates the history,
// extremes and counter and forms the window sum; stage two divides by the window length with
// a single reciprocal multiply and forms the step and grade; stage three latches the reference
// average, forms the drift and holds the result. Each stage moves on when the next one is free,
// so a stalled output fills the empty stages before input stalls. Reset is asynchronous.
`include "assert_macros.svh"

module free_memory_trend_monitor_top
  import fmtm_pkg::*;
#(
  parameter int unsigned WINDOW_PAST = WINDOW_PAST_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int unsigned AVG_W   = SAMPLE_BITS + 4,
  localparam int unsigned STEP_W  = SAMPLE_BITS + 1,
  localparam int unsigned DRIFT_W = SAMPLE_BITS + 5,
  localparam int unsigned OUT_BITS = 2 + AVG_W + 1 + STEP_W + DRIFT_W + 2 * SAMPLE_BITS,
  localparam int unsigned OUT_W   = ((OUT_BITS + 7) / 8) * 8,
  localparam int unsigned IN_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [IN_W-1:0]    s_axis_tdata,   // free_bytes
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // level, average_q4, average_valid, step_change, drift_q4, lowest_seen, highest_seen
  output logic [OUT_W-1:0]   m_axis_tdata,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_A_W-1:0] cfg_addr_i,
  input  logic [THR_W-1:0]   cfg_data_i
);

  localparam int unsigned DIV      = WINDOW_PAST + 1;
  localparam int unsigned DIV_BITS = $clog2(DIV);
  localparam int unsigned SUM_W    = SAMPLE_BITS + DIV_BITS;
  localparam int unsigned X_W      = SUM_W + 4;
  localparam int unsigned SHIFT    = X_W + DIV_BITS;
  localparam int unsigned M_W      = X_W + 1;
  localparam int unsigned PROD_W   = X_W + M_W;
  localparam logic [63:0] RECIP    = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam int unsigned CMP_W    = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  localparam int unsigned OFS_AVG   = 2;
  localparam int unsigned OFS_VALID = OFS_AVG + AVG_W;
  localparam int unsigned OFS_STEP  = OFS_VALID + 1;
  localparam int unsigned OFS_DRIFT = OFS_STEP + STEP_W;
  localparam int unsigned OFS_LOW   = OFS_DRIFT + DRIFT_W;
  localparam int unsigned OFS_HIGH  = OFS_LOW + SAMPLE_BITS;

  // Configuration registers.
  logic [THR_W-1:0] warn_q, danger_q;
  logic [CNT_W-1:0] ref_pt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_q   <= WARN_RESET;
      danger_q <= DANGER_RESET;
      ref_pt_q <= REF_PT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_WARNING:   warn_q   <= cfg_data_i;
        CFG_DANGER:    danger_q <= cfg_data_i;
        CFG_REF_POINT: ref_pt_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  logic v1_q, v2_q, v3_q;
  logic adv2, adv3, in_acc;

  assign adv3          = v2_q && (!v3_q || m_axis_tready);
  assign adv2          = v1_q && (!v2_q || adv3);
  assign s_axis_tready = !v1_q || adv2;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (in_acc) begin
        v1_q <= 1'b1;
      end else if (adv2) begin
        v1_q <= 1'b0;
      end
      if (adv2) begin
        v2_q <= 1'b1;
      end else if (adv3) begin
        v2_q <= 1'b0;
      end
      if (adv3) begin
        v3_q <= 1'b1;
      end else if (m_axis_tready) begin
        v3_q <= 1'b0;
      end
    end
  end

  // Stage one: running state and window sum.
  logic [SAMPLE_BITS-1:0] hist_q [WINDOW_PAST];
  logic [CNT_W-1:0]       cnt_q;
  logic [SAMPLE_BITS-1:0] peak_q, trough_q;
  logic [SAMPLE_BITS-1:0] cur;
  logic [SAMPLE_BITS-1:0] peak_d, trough_d;
  logic [SUM_W-1:0]       sum_d;

  assign cur = s_axis_tdata[SAMPLE_BITS-1:0];

  always_comb begin
    peak_d   = (cur > peak_q) ? cur : peak_q;
    trough_d = (cur < trough_q || trough_q == '0) ? cur : trough_q;
    sum_d    = SUM_W'(cur);
    for (int i = 0; i < WINDOW_PAST; i++) begin
      sum_d = sum_d + SUM_W'(hist_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_PAST; i++) begin
        hist_q[i] <= '0;
      end
      cnt_q    <= '0;
      peak_q   <= '0;
      trough_q <= '0;
    end else if (in_acc) begin
      hist_q[0] <= cur;
      for (int i = 1; i < WINDOW_PAST; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
      if (cnt_q != CNT_MAX) begin
        cnt_q <= cnt_q + 1'b1;
      end
      peak_q   <= peak_d;
      trough_q <= trough_d;
    end
  end

  logic [SAMPLE_BITS-1:0] cur1_q, prev1_q, peak1_q, trough1_q;
  logic [SUM_W-1:0]       sum1_q;
  logic                   valid1_q, latch1_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur1_q    <= cur;
      prev1_q   <= hist_q[0];
      sum1_q    <= sum_d;
      valid1_q  <= (cnt_q > CNT_W'(WINDOW_PAST));
      latch1_q  <= (cnt_q == ref_pt_q);
      peak1_q   <= peak_d;
      trough1_q <= trough_d;
    end
  end

  // Stage two: divide by the window length, step and grading.
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] usage;
  logic [CMP_W-1:0]       usage_x;
  level_e                 level_d;
  logic [STEP_W-1:0]      step_d;

  // The reciprocal is rounded up with enough extra bits that the quotient is exact.
  assign prod    = PROD_W'({sum1_q, 4'b0000}) * PROD_W'(RECIP[M_W-1:0]);
  assign usage   = peak1_q - cur1_q;
  assign usage_x = CMP_W'(usage);

  always_comb begin
    if (usage_x > CMP_W'(danger_q)) begin
      level_d = LVL_DANGER;
    end else if (usage_x > CMP_W'(warn_q)) begin
      level_d = LVL_WARNING;
    end else begin
      level_d = LVL_NORMAL;
    end
    step_d = valid1_q ? ({1'b0, cur1_q} - {1'b0, prev1_q}) : '0;
  end

  logic [AVG_W-1:0]       avg2_q;
  logic [STEP_W-1:0]      step2_q;
  level_e                 level2_q;
  logic                   valid2_q, latch2_q;
  logic [SAMPLE_BITS-1:0] peak2_q, trough2_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      avg2_q    <= valid1_q ? prod[SHIFT +: AVG_W] : '0;
      step2_q   <= step_d;
      level2_q  <= level_d;
      valid2_q  <= valid1_q;
      latch2_q  <= latch1_q;
      peak2_q   <= peak1_q;
      trough2_q <= trough1_q;
    end
  end

  // Stage three: reference latch, drift and the result register.
  logic [SAMPLE_BITS-1:0] ref_q, ref_d;
  logic [DRIFT_W-1:0]     drift_d;

  always_comb begin
    ref_d   = latch2_q ? avg2_q[4 +: SAMPLE_BITS] : ref_q;
    drift_d = DRIFT_W'(avg2_q) - DRIFT_W'({ref_d, 4'b0000});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
    end else if (adv3) begin
      ref_q <= ref_d;
    end
  end

  level_e                 level3_q;
  logic [AVG_W-1:0]       avg3_q;
  logic                   valid3_q;
  logic [STEP_W-1:0]      step3_q;
  logic [DRIFT_W-1:0]     drift3_q;
  logic [SAMPLE_BITS-1:0] low3_q, high3_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      level3_q <= level2_q;
      avg3_q   <= avg2_q;
      valid3_q <= valid2_q;
      step3_q  <= step2_q;
      drift3_q <= drift_d;
      low3_q   <= trough2_q;
      high3_q  <= peak2_q;
    end
  end

  always_comb begin
    m_axis_tdata                          = '0;
    m_axis_tdata[1:0]                     = level3_q;
    m_axis_tdata[OFS_AVG +: AVG_W]        = avg3_q;
    m_axis_tdata[OFS_VALID]               = valid3_q;
    m_axis_tdata[OFS_STEP +: STEP_W]      = step3_q;
    m_axis_tdata[OFS_DRIFT +: DRIFT_W]    = drift3_q;
    m_axis_tdata[OFS_LOW +: SAMPLE_BITS]  = low3_q;
    m_axis_tdata[OFS_HIGH +: SAMPLE_BITS] = high3_q;
  end

  // Checks.
  `ASSERT_IMPLIES(a_trough_below_peak, clk_i, rst_ni, trough_q != '0, peak_q >= trough_q)
  `ASSERT_NEXT(a_counter_saturates, clk_i, rst_ni, cnt_q == CNT_MAX, cnt_q == CNT_MAX)
  `ASSERT_IMPLIES(a_invalid_zero, clk_i, rst_ni, v3_q && !valid3_q, avg3_q == '0 && step3_q == '0)

endmodule

// ===== verif/tb_free_memory_trend_monitor_top.sv =====
// Self-checking testbench for the free-memory trend monitor top level.
`timescale 1ns / 1ps

module tb_free_memory_trend_monitor_top
  import fmtm_pkg::*;
();

  localparam int unsigned HISTORY_LEN = WINDOW_PAST_DEF;
  localparam int unsigned SAMPLE_W    = SAMPLE_BITS_DEF;
  localparam int unsigned IN_W        = ((SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned OUT_BITS    = 2 + (SAMPLE_W + 4) + 1 + (SAMPLE_W + 1) + (SAMPLE_W + 5)
                                        + 2 * SAMPLE_W;
  localparam int unsigned OUT_W       = ((OUT_BITS + 7) / 8) * 8;

  localparam int unsigned LVL_LSB   = 0;
  localparam int unsigned AVG_LSB   = 2;
  localparam int unsigned VLD_LSB   = AVG_LSB + SAMPLE_W + 4;
  localparam int unsigned STEP_LSB  = VLD_LSB + 1;
  localparam int unsigned DRIFT_LSB = STEP_LSB + SAMPLE_W + 1;
  localparam int unsigned LOW_LSB   = DRIFT_LSB + SAMPLE_W + 5;
  localparam int unsigned HIGH_LSB  = LOW_LSB + SAMPLE_W;

  localparam logic [CFG_A_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam logic [SAMPLE_W-1:0] FREE_MAX    = '1;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct {
    level_e                level;
    logic [SAMPLE_W+3:0]   average_q4;
    logic                  average_valid;
    logic [SAMPLE_W:0]     step_change;
    logic [SAMPLE_W+4:0]   drift_q4;
    logic [SAMPLE_W-1:0]   lowest_seen;
    logic [SAMPLE_W-1:0]   highest_seen;
  } trend_report_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CFG_A_W-1:0] cfg_addr_i;
  logic [THR_W-1:0]   cfg_data_i;

  // Mirror of the monitor's state and registers.
  logic [SAMPLE_W-1:0] history_q [HISTORY_LEN];
  logic [CNT_W-1:0]    count_q;
  logic [SAMPLE_W-1:0] peak_q;
  logic [SAMPLE_W-1:0] trough_q;
  logic [SAMPLE_W-1:0] ref_avg_q;
  logic [THR_W-1:0]    warn_thr;
  logic [THR_W-1:0]    danger_thr;
  logic [CNT_W-1:0]    ref_point;

  trend_report_t pending_reports[$];
  int unsigned   mismatches;
  int unsigned   failures;
  int unsigned   cycle_count;
  int unsigned   stall_left;
  bit            tx_idle_en;
  bit            rx_stall_en;

  free_memory_trend_monitor_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** free_memory_trend_monitor_top: FAILED **");
      $finish;
    end
  end

  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Output back-pressure: mostly short stalls, now and then a long one.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_en && $urandom_range(0, 99) < 25) begin
      stall_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic compute_trend_report(input logic [SAMPLE_W-1:0] cur);
    logic [SAMPLE_W-1:0] prev;
    logic [63:0]         sum;
    logic [63:0]         avg_q4;
    logic [63:0]         avg_int;
    logic [63:0]         step;
    logic [63:0]         drift;
    logic [63:0]         usage;
    trend_report_t       rep;
    prev = history_q[0];
    if (cur > peak_q) peak_q = cur;
    if (cur < trough_q || trough_q == '0) trough_q = cur;
    sum = 64'(cur);
    for (int i = 0; i < HISTORY_LEN; i++) begin
      sum += 64'(history_q[i]);
    end
    for (int i = HISTORY_LEN - 1; i > 0; i--) begin
      history_q[i] = history_q[i-1];
    end
    history_q[0] = cur;
    rep.average_valid = (count_q > HISTORY_LEN);
    avg_q4  = '0;
    avg_int = '0;
    step    = '0;
    if (rep.average_valid) begin
      avg_q4  = (sum * 16) / (HISTORY_LEN + 1);
      avg_int = sum / (HISTORY_LEN + 1);
      step    = 64'(cur) - 64'(prev);
    end
    if (count_q == ref_point) ref_avg_q = avg_int[SAMPLE_W-1:0];
    usage = 64'(peak_q) - 64'(cur);
    if (usage > 64'(danger_thr)) begin
      rep.level = LVL_DANGER;
    end else if (usage > 64'(warn_thr)) begin
      rep.level = LVL_WARNING;
    end else begin
      rep.level = LVL_NORMAL;
    end
    drift = avg_q4 - 64'(ref_avg_q) * 16;
    rep.average_q4   = avg_q4[SAMPLE_W+3:0];
    rep.step_change  = step[SAMPLE_W:0];
    rep.drift_q4     = drift[SAMPLE_W+4:0];
    rep.lowest_seen  = trough_q;
    rep.highest_seen = peak_q;
    if (count_q != CNT_MAX) count_q++;
    pending_reports.push_back(rep);
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    mismatches++;
    failures++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, field, exp_v, act_v);
    end
  endtask

  // Every output transfer is compared with the oldest outstanding report.
  always @(posedge clk_i) begin
    trend_report_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        note_mismatch("unexpected transfer", '0, 64'(m_axis_tdata[HIGH_LSB +: SAMPLE_W]));
      end else begin
        exp_r = pending_reports.pop_front();
        if (m_axis_tdata[LVL_LSB +: 2] !== exp_r.level)
          note_mismatch("level", exp_r.level, m_axis_tdata[LVL_LSB +: 2]);
        if (m_axis_tdata[AVG_LSB +: SAMPLE_W+4] !== exp_r.average_q4)
          note_mismatch("average_q4", exp_r.average_q4, m_axis_tdata[AVG_LSB +: SAMPLE_W+4]);
        if (m_axis_tdata[VLD_LSB] !== exp_r.average_valid)
          note_mismatch("average_valid", exp_r.average_valid, m_axis_tdata[VLD_LSB]);
        if (m_axis_tdata[STEP_LSB +: SAMPLE_W+1] !== exp_r.step_change)
          note_mismatch("step_change", exp_r.step_change, m_axis_tdata[STEP_LSB +: SAMPLE_W+1]);
        if (m_axis_tdata[DRIFT_LSB +: SAMPLE_W+5] !== exp_r.drift_q4)
          note_mismatch("drift_q4", exp_r.drift_q4, m_axis_tdata[DRIFT_LSB +: SAMPLE_W+5]);
        if (m_axis_tdata[LOW_LSB +: SAMPLE_W] !== exp_r.lowest_seen)
          note_mismatch("lowest_seen", exp_r.lowest_seen, m_axis_tdata[LOW_LSB +: SAMPLE_W]);
        if (m_axis_tdata[HIGH_LSB +: SAMPLE_W] !== exp_r.highest_seen)
          note_mismatch("highest_seen", exp_r.highest_seen, m_axis_tdata[HIGH_LSB +: SAMPLE_W]);
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] free_bytes);
    int unsigned gap;
    gap = pick_gap(tx_idle_en);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_W'(free_bytes);
    do @(posedge clk_i); while (!s_axis_tready);
    compute_trend_report(free_bytes);
  endtask

  // Lets the pipeline drain so that the registers can be written safely.
  task automatic wait_until_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_A_W-1:0] idx, input logic [THR_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_addr_i  = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_WARNING:   warn_thr   = value;
      CFG_DANGER:    danger_thr = value;
      CFG_REF_POINT: ref_point  = value[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Samples mostly sit just below the peak so that every grade is reached.
  function automatic logic [SAMPLE_W-1:0] pick_free_bytes();
    int unsigned r;
    int unsigned dip;
    r = $urandom_range(0, 99);
    if (r < 12) return SAMPLE_W'($urandom);
    if (r < 16) return '0;
    if (r < 20) return FREE_MAX;
    if (r < 23) return SAMPLE_W'(1);
    dip = $urandom_range(0, 250000);
    if (r < 30) begin
      return (peak_q < FREE_MAX - 1000) ? SAMPLE_W'(peak_q + $urandom_range(1, 1000)) : peak_q;
    end
    if (peak_q > dip) return SAMPLE_W'(peak_q - dip);
    return SAMPLE_W'($urandom_range(0, 1000));
  endfunction

  task automatic test_defaults_and_edges();
    logic [SAMPLE_W-1:0] edge_samples [] = '{
      24'd0, 24'd0, FREE_MAX, 24'd0, 24'd1, FREE_MAX, 24'd0, FREE_MAX,
      SAMPLE_W'(FREE_MAX - 100000), SAMPLE_W'(FREE_MAX - 80000), SAMPLE_W'(FREE_MAX - 80001),
      SAMPLE_W'(FREE_MAX - 120000), SAMPLE_W'(FREE_MAX - 120001), 24'd5, 24'd0, 24'd77,
      FREE_MAX, 24'h555555, 24'hAAAAAA, FREE_MAX
    };
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    foreach (edge_samples[i]) send_sample(edge_samples[i]);
    wait_until_idle();
  endtask

  task automatic test_threshold_extremes();
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    // A reference point already passed never latches again.
    write_register(CFG_REF_POINT, '0);
    write_register(CFG_UNMAPPED, THR_W'($urandom));
    write_register(CFG_WARNING, '0);
    write_register(CFG_DANGER, '0);
    repeat (12) send_sample(pick_free_bytes());
    wait_until_idle();
    write_register(CFG_WARNING, '1);
    write_register(CFG_DANGER, '1);
    repeat (12) send_sample(pick_free_bytes());
    wait_until_idle();
    write_register(CFG_WARNING, '0);
    write_register(CFG_DANGER, '1);
    repeat (12) send_sample(pick_free_bytes());
    wait_until_idle();
  endtask

  task automatic test_random_trend();
    logic [THR_W-1:0] warn_v;
    int unsigned      hi_pt;
    for (int phase = 0; phase < 5; phase++) begin
      warn_v = THR_W'($urandom_range(0, 150000));
      write_register(CFG_WARNING, warn_v);
      write_register(CFG_DANGER, THR_W'($urandom_range(warn_v, 250000)));
      case (phase)
        0: begin
          hi_pt = (count_q + 100 < 253) ? count_q + 100 : 253;
          write_register(CFG_REF_POINT, THR_W'($urandom_range(count_q + 1, hi_pt)));
        end
        1: write_register(CFG_REF_POINT, THR_W'(254));
        // At 255 the saturated counter latches the reference on every sample.
        2: write_register(CFG_REF_POINT, THR_W'(CNT_MAX));
        default: write_register(CFG_REF_POINT, THR_W'($urandom_range(6, 255)));
      endcase
      for (int n = 0; n < 100; n++) begin
        if (n % 40 == 0) begin
          tx_idle_en  = ($urandom_range(0, 3) != 0);
          rx_stall_en = ($urandom_range(0, 3) != 0);
        end
        send_sample(pick_free_bytes());
      end
      wait_until_idle();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = CFG_WARNING;
    cfg_data_i    = '0;
    mismatches    = 0;
    failures      = 0;
    cycle_count   = 0;
    stall_left    = 0;
    tx_idle_en    = 1'b0;
    rx_stall_en   = 1'b0;
    foreach (history_q[i]) history_q[i] = '0;
    count_q    = '0;
    peak_q     = '0;
    trough_q   = '0;
    ref_avg_q  = '0;
    warn_thr   = WARN_RESET;
    danger_thr = DANGER_RESET;
    ref_point  = REF_PT_RESET;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_defaults_and_edges();
    test_threshold_extremes();
    test_random_trend();

    wait_until_idle();
    failures += pending_reports.size();
    if (failures == 0) begin
      $display("** free_memory_trend_monitor_top: PASSED **");
    end else begin
      $display("** free_memory_trend_monitor_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fmtm_pkg.sv
rtl/free_memory_trend_monitor_top.sv
verif/tb_free_memory_trend_monitor_top.sv
